// ----- src/hcam_pkg.sv -----
// Shared types and constants for the half-cycle average meter.
`timescale 1ns / 1ps
`default_nettype none

package hcam_pkg;

    localparam int SAMPLE_WIDTH_DEF = 16;
    localparam int COUNT_WIDTH_DEF  = 16;
    localparam int SUM_WIDTH        = 32;
    localparam int TIMER_WIDTH      = 16;
    localparam int THR_WIDTH        = 15;
    localparam int BAND_WIDTH       = 16;
    localparam int HOLD_WIDTH       = 16;
    localparam int CFG_DATA_WIDTH   = 16;
    localparam int CFG_INDEX_WIDTH  = 2;

    // Register indexes
    localparam logic [CFG_INDEX_WIDTH-1:0] REG_CROSSING_THRESHOLD = 2'd0;
    localparam logic [CFG_INDEX_WIDTH-1:0] REG_ZERO_BAND_UPPER    = 2'd1;
    localparam logic [CFG_INDEX_WIDTH-1:0] REG_ZERO_BAND_LOWER    = 2'd2;
    localparam logic [CFG_INDEX_WIDTH-1:0] REG_ZERO_HOLD_SAMPLES  = 2'd3;

    // Reset values
    localparam logic [THR_WIDTH-1:0]  RST_CROSSING_THRESHOLD = 15'd1;
    localparam logic [BAND_WIDTH-1:0] RST_ZERO_BAND_UPPER    = 16'd0;
    localparam logic [BAND_WIDTH-1:0] RST_ZERO_BAND_LOWER    = 16'd0;
    localparam logic [HOLD_WIDTH-1:0] RST_ZERO_HOLD_SAMPLES  = 16'd1000;

    typedef struct packed {
        logic [THR_WIDTH-1:0]  crossing_threshold;
        logic [BAND_WIDTH-1:0] zero_band_upper;
        logic [BAND_WIDTH-1:0] zero_band_lower;
        logic [HOLD_WIDTH-1:0] zero_hold_samples;
    } cfg_t;

    typedef enum logic [2:0] {
        ST_IDLE = 3'b001,
        ST_DIV  = 3'b010,
        ST_DONE = 3'b100
    } state_t;

endpackage

`default_nettype wire

// ----- src/hcam_if.sv -----
// Sample and result channel interfaces.
`timescale 1ns / 1ps
`default_nettype none

interface hcam_sample_if
    import hcam_pkg::*;
#(
    parameter int SAMPLE_WIDTH = SAMPLE_WIDTH_DEF
);
    logic                           valid;
    logic                           ready;
    logic signed [SAMPLE_WIDTH-1:0] sample;

    modport source (output valid, output sample, input ready);
    modport sink   (input valid, input sample, output ready);
endinterface

interface hcam_result_if
    import hcam_pkg::*;
#(
    parameter int SAMPLE_WIDTH = SAMPLE_WIDTH_DEF
);
    logic                    valid;
    logic                    ready;
    logic [SAMPLE_WIDTH-1:0] level;
    logic                    level_updated;
    logic                    zero_forced;

    modport source (output valid, output level, output level_updated, output zero_forced,
                    input ready);
    modport sink   (input valid, input level, input level_updated, input zero_forced,
                    output ready);
endinterface

`default_nettype wire

// ----- src/half_cycle_average_meter_top.sv -----
// Half-cycle rectified average meter, top level.
`timescale 1ns / 1ps
`default_nettype none

// Takes one signed sample per beat and returns one result beat per sample: the
// level (mean magnitude of the last completed half period), a flag when a polarity
// change recomputed it, and a flag when the zero-band timeout cleared it. A sample
// that closes a half period with a nonzero count is accepted, runs through the
// restoring divider (one quotient bit per cycle over the 32-bit magnitude sum),
// then has its level written back; any other sample goes straight to write-back.
// The input is not ready while a sample is in work; a finished result waits in the
// output register and does not hold off the next sample, only its write-back.
module half_cycle_average_meter_top
    import hcam_pkg::*;
#(
    parameter int SAMPLE_WIDTH = SAMPLE_WIDTH_DEF,
    parameter int COUNT_WIDTH  = COUNT_WIDTH_DEF
)
(
    input  wire logic                       clk,
    input  wire logic                       rst_n,
    hcam_sample_if.sink                     samples,
    hcam_result_if.source                   results,
    input  wire logic                       cfg_we,
    input  wire logic [CFG_INDEX_WIDTH-1:0] cfg_index,
    input  wire logic [CFG_DATA_WIDTH-1:0]  cfg_data
);

    localparam int CMP_W = ((SAMPLE_WIDTH > BAND_WIDTH) ? SAMPLE_WIDTH : BAND_WIDTH) + 2;
    localparam logic [SUM_WIDTH-1:0] LEVEL_MAX = SUM_WIDTH'(1) << (SAMPLE_WIDTH - 1);

    cfg_t cfg;

    hcam_cfg u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    state_t                  state_reg;
    logic                    pol_reg;
    logic [SUM_WIDTH-1:0]    sum_reg;
    logic [COUNT_WIDTH-1:0]  count_reg;
    logic [TIMER_WIDTH-1:0]  timer_reg;
    logic [SAMPLE_WIDTH-1:0] level_reg;
    logic                    upd_reg;
    logic                    forced_reg;

    logic                    out_valid_reg;
    logic [SAMPLE_WIDTH-1:0] out_level_reg;
    logic                    out_upd_reg;
    logic                    out_forced_reg;

    logic                    accept;
    logic signed [CMP_W-1:0] s_ext;
    logic signed [CMP_W-1:0] thr_ext;
    logic signed [CMP_W-1:0] neg_thr;
    logic signed [CMP_W-1:0] upper_ext;
    logic signed [CMP_W-1:0] lower_ext;
    logic                    cross_pos;
    logic                    cross_neg;
    logic                    close_half;
    logic                    recompute;
    logic [SAMPLE_WIDTH-1:0] mag;
    logic [SUM_WIDTH-1:0]    sum_base;
    logic [COUNT_WIDTH-1:0]  count_base;
    logic [SUM_WIDTH:0]      sum_wide;
    logic [SUM_WIDTH-1:0]    sum_next;
    logic [COUNT_WIDTH-1:0]  count_next;
    logic                    in_band;
    logic [TIMER_WIDTH-1:0]  timer_next;
    logic                    forced_next;

    logic                    div_done;
    logic [SUM_WIDTH-1:0]    quotient;
    logic [SAMPLE_WIDTH-1:0] mean_clamped;
    logic [SAMPLE_WIDTH-1:0] level_next;
    logic                    out_free;

    assign accept = samples.valid && samples.ready;
    assign samples.ready = (state_reg == ST_IDLE);

    assign s_ext     = CMP_W'(samples.sample);
    assign thr_ext   = CMP_W'($signed({1'b0, cfg.crossing_threshold}));
    assign neg_thr   = -thr_ext;
    assign upper_ext = CMP_W'($signed(cfg.zero_band_upper));
    assign lower_ext = CMP_W'($signed(cfg.zero_band_lower));

    assign cross_pos  = (s_ext > thr_ext) && !pol_reg;
    assign cross_neg  = (s_ext < neg_thr) && pol_reg;
    assign close_half = cross_pos || cross_neg;
    assign recompute  = close_half && (count_reg != '0);

    assign mag        = samples.sample[SAMPLE_WIDTH-1] ? (~samples.sample + 1'b1)
                                                       : samples.sample;
    assign sum_base   = close_half ? '0 : sum_reg;
    assign count_base = close_half ? '0 : count_reg;
    assign sum_wide   = {1'b0, sum_base} + (SUM_WIDTH + 1)'(mag);
    // saturate the sum and the count
    assign sum_next   = sum_wide[SUM_WIDTH] ? '1 : sum_wide[SUM_WIDTH-1:0];
    assign count_next = (count_base == '1) ? count_base : count_base + 1'b1;

    assign in_band     = (s_ext < upper_ext) && (s_ext > lower_ext);
    assign timer_next  = !in_band ? '0
                       : ((timer_reg == '1) ? timer_reg : timer_reg + 1'b1);
    assign forced_next = timer_next >= cfg.zero_hold_samples;

    hcam_div #(
        .DIVIDEND_WIDTH (SUM_WIDTH),
        .DIVISOR_WIDTH  (COUNT_WIDTH)
    ) u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (accept && recompute),
        .dividend (sum_reg),
        .divisor  (count_reg),
        .done     (div_done),
        .quotient (quotient)
    );

    assign mean_clamped = (quotient > LEVEL_MAX) ? LEVEL_MAX[SAMPLE_WIDTH-1:0]
                                                 : quotient[SAMPLE_WIDTH-1:0];
    // timeout wins over a recompute in the same sample
    assign level_next   = forced_reg ? '0 : (upd_reg ? mean_clamped : level_reg);
    assign out_free     = !out_valid_reg || results.ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            pol_reg       <= 1'b0;
            sum_reg       <= '0;
            count_reg     <= '0;
            timer_reg     <= '0;
            level_reg     <= '0;
            upd_reg       <= 1'b0;
            forced_reg    <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (state_reg == ST_DONE && out_free)
                out_valid_reg <= 1'b1;
            else if (out_valid_reg && results.ready)
                out_valid_reg <= 1'b0;

            unique case (state_reg)
                ST_IDLE:
                begin
                    if (accept)
                    begin
                        if (cross_pos)
                            pol_reg <= 1'b1;
                        else if (cross_neg)
                            pol_reg <= 1'b0;
                        sum_reg    <= sum_next;
                        count_reg  <= count_next;
                        timer_reg  <= timer_next;
                        upd_reg    <= recompute;
                        forced_reg <= forced_next;
                        state_reg  <= recompute ? ST_DIV : ST_DONE;
                    end
                end
                ST_DIV:
                begin
                    if (div_done)
                        state_reg <= ST_DONE;
                end
                ST_DONE:
                begin
                    if (out_free)
                    begin
                        level_reg <= level_next;
                        state_reg <= ST_IDLE;
                    end
                end
                default: state_reg <= ST_IDLE;
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        if (state_reg == ST_DONE && out_free)
        begin
            out_level_reg  <= level_next;
            out_upd_reg    <= upd_reg;
            out_forced_reg <= forced_reg;
        end
    end

    assign results.valid         = out_valid_reg;
    assign results.level         = out_level_reg;
    assign results.level_updated = out_upd_reg;
    assign results.zero_forced   = out_forced_reg;

endmodule

`default_nettype wire

// ----- src/hcam_cfg.sv -----
// Configuration register file.
`timescale 1ns / 1ps
`default_nettype none

module hcam_cfg
    import hcam_pkg::*;
(
    input  wire logic                       clk,
    input  wire logic                       rst_n,
    input  wire logic                       cfg_we,
    input  wire logic [CFG_INDEX_WIDTH-1:0] cfg_index,
    input  wire logic [CFG_DATA_WIDTH-1:0]  cfg_data,
    output cfg_t                            cfg
);

    cfg_t cfg_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.crossing_threshold <= RST_CROSSING_THRESHOLD;
            cfg_reg.zero_band_upper    <= RST_ZERO_BAND_UPPER;
            cfg_reg.zero_band_lower    <= RST_ZERO_BAND_LOWER;
            cfg_reg.zero_hold_samples  <= RST_ZERO_HOLD_SAMPLES;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                REG_CROSSING_THRESHOLD: cfg_reg.crossing_threshold <= cfg_data[THR_WIDTH-1:0];
                REG_ZERO_BAND_UPPER:    cfg_reg.zero_band_upper    <= cfg_data[BAND_WIDTH-1:0];
                REG_ZERO_BAND_LOWER:    cfg_reg.zero_band_lower    <= cfg_data[BAND_WIDTH-1:0];
                REG_ZERO_HOLD_SAMPLES:  cfg_reg.zero_hold_samples  <= cfg_data[HOLD_WIDTH-1:0];
                default: ;
            endcase
        end
    end

    assign cfg = cfg_reg;

endmodule

`default_nettype wire

// ----- src/hcam_div.sv -----
// Restoring divider, one quotient bit per cycle.
`timescale 1ns / 1ps
`default_nettype none

module hcam_div
    import hcam_pkg::*;
#(
    parameter int DIVIDEND_WIDTH = SUM_WIDTH,
    parameter int DIVISOR_WIDTH  = COUNT_WIDTH_DEF
)
(
    input  wire logic                      clk,
    input  wire logic                      rst_n,
    input  wire logic                      start,
    input  wire logic [DIVIDEND_WIDTH-1:0] dividend,
    input  wire logic [DIVISOR_WIDTH-1:0]  divisor,
    output logic                           done,
    output logic [DIVIDEND_WIDTH-1:0]      quotient
);

    localparam int STEP_W = $clog2(DIVIDEND_WIDTH);

    logic                      busy_reg;
    logic [STEP_W-1:0]         step_reg;
    logic [DIVISOR_WIDTH:0]    rem_reg;
    logic [DIVIDEND_WIDTH-1:0] quot_reg;
    logic [DIVISOR_WIDTH-1:0]  divisor_reg;

    logic [DIVISOR_WIDTH:0]    shifted;
    logic [DIVISOR_WIDTH:0]    diff;
    logic                      fits;

    assign shifted = {rem_reg[DIVISOR_WIDTH-1:0], quot_reg[DIVIDEND_WIDTH-1]};
    assign fits    = shifted >= {1'b0, divisor_reg};
    assign diff    = shifted - {1'b0, divisor_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            step_reg <= '0;
        end
        else if (start)
        begin
            busy_reg <= 1'b1;
            step_reg <= STEP_W'(DIVIDEND_WIDTH - 1);
        end
        else if (busy_reg)
        begin
            if (step_reg == '0)
                busy_reg <= 1'b0;
            else
                step_reg <= step_reg - 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            quot_reg    <= dividend;
            rem_reg     <= '0;
            divisor_reg <= divisor;
        end
        else if (busy_reg)
        begin
            quot_reg <= {quot_reg[DIVIDEND_WIDTH-2:0], fits};
            rem_reg  <= fits ? diff : shifted;
        end
    end

    assign done     = busy_reg && (step_reg == '0);
    assign quotient = quot_reg;

endmodule

`default_nettype wire

// ----- verif/half_cycle_average_meter_checker.sv -----
// Checker for the half-cycle average meter: predicts each result beat and compares it.
`timescale 1ns / 1ps

module half_cycle_average_meter_checker
    import hcam_pkg::*;
(
    input  wire logic                       clk,
    input  wire logic                       rst_n,
    hcam_sample_if                          samples,
    hcam_result_if                          results,
    input  wire logic                       cfg_we,
    input  wire logic [CFG_INDEX_WIDTH-1:0] cfg_index,
    input  wire logic [CFG_DATA_WIDTH-1:0]  cfg_data,
    output int                              mismatches,
    output int                              outstanding,
    output int                              beats_checked,
    output int                              recomputes_seen,
    output int                              clears_seen
);

    typedef struct packed {
        logic [SAMPLE_WIDTH_DEF-1:0] level;
        logic                        level_updated;
        logic                        zero_forced;
    } meter_beat_t;

    localparam logic [SAMPLE_WIDTH_DEF-1:0] LEVEL_CEIL =
        SAMPLE_WIDTH_DEF'(1) << (SAMPLE_WIDTH_DEF - 1);

    // register copies
    logic [THR_WIDTH-1:0]         thr_q;
    logic signed [BAND_WIDTH-1:0] band_hi_q;
    logic signed [BAND_WIDTH-1:0] band_lo_q;
    logic [HOLD_WIDTH-1:0]        hold_q;

    // meter state
    logic                         half_pos;
    logic [SUM_WIDTH-1:0]         half_sum;
    logic [COUNT_WIDTH_DEF-1:0]   half_cnt;
    logic [TIMER_WIDTH-1:0]       quiet_run;
    logic [SAMPLE_WIDTH_DEF-1:0]  level_q;

    meter_beat_t pending_levels[$];

    // Advance the meter by one sample and return the beat it should produce.
    task automatic meter_step(input logic signed [SAMPLE_WIDTH_DEF-1:0] s,
                              output meter_beat_t beat);
        int                   s_val;
        int                   thr;
        logic [SUM_WIDTH-1:0] mag;
        logic [SUM_WIDTH:0]   total;
        logic [SUM_WIDTH-1:0] mean;
        beat  = '0;
        s_val = s;
        thr   = {17'd0, thr_q};
        // the two crossing tests cannot both fire on one sample
        if ((s_val > thr && !half_pos) || (s_val < -thr && half_pos))
        begin
            if (half_cnt != '0)
            begin
                mean    = half_sum / SUM_WIDTH'(half_cnt);
                level_q = (mean > SUM_WIDTH'(LEVEL_CEIL)) ? LEVEL_CEIL
                                                           : mean[SAMPLE_WIDTH_DEF-1:0];
                beat.level_updated = 1'b1;
            end
            half_sum = '0;
            half_cnt = '0;
            half_pos = !half_pos;
        end
        mag      = (s_val < 0) ? SUM_WIDTH'(-s_val) : SUM_WIDTH'(s_val);
        total    = {1'b0, half_sum} + {1'b0, mag};
        half_sum = total[SUM_WIDTH] ? '1 : total[SUM_WIDTH-1:0];
        if (half_cnt != '1)
            half_cnt = half_cnt + 1'b1;
        if (s_val < int'(band_hi_q) && s_val > int'(band_lo_q))
        begin
            if (quiet_run != '1)
                quiet_run = quiet_run + 1'b1;
        end
        else
            quiet_run = '0;
        // timeout wins over a recompute in the same sample
        if (quiet_run >= hold_q)
        begin
            level_q          = '0;
            beat.zero_forced = 1'b1;
        end
        beat.level = level_q;
    endtask

    always @(posedge clk or negedge rst_n)
    begin : track
        meter_beat_t want;
        if (!rst_n)
        begin
            thr_q     = RST_CROSSING_THRESHOLD;
            band_hi_q = RST_ZERO_BAND_UPPER;
            band_lo_q = RST_ZERO_BAND_LOWER;
            hold_q    = RST_ZERO_HOLD_SAMPLES;
            half_pos  = 1'b0;
            half_sum  = '0;
            half_cnt  = '0;
            quiet_run = '0;
            level_q   = '0;
            pending_levels.delete();
            mismatches      = 0;
            beats_checked   = 0;
            recomputes_seen = 0;
            clears_seen     = 0;
            outstanding <= 0;
        end
        else
        begin
            // result side first so a beat never meets an expectation pushed this edge
            if (results.valid && results.ready)
            begin
                beats_checked++;
                if (results.level_updated)
                    recomputes_seen++;
                if (results.zero_forced)
                    clears_seen++;
                if (pending_levels.size() == 0)
                begin
                    mismatches++;
                    $error("unexpected result beat: level=%0d level_updated=%0b zero_forced=%0b",
                           results.level, results.level_updated, results.zero_forced);
                end
                else
                begin
                    want = pending_levels.pop_front();
                    if (results.level !== want.level)
                    begin
                        mismatches++;
                        $error("level: expected %0d, got %0d", want.level, results.level);
                    end
                    if (results.level_updated !== want.level_updated)
                    begin
                        mismatches++;
                        $error("level_updated: expected %0b, got %0b",
                               want.level_updated, results.level_updated);
                    end
                    if (results.zero_forced !== want.zero_forced)
                    begin
                        mismatches++;
                        $error("zero_forced: expected %0b, got %0b",
                               want.zero_forced, results.zero_forced);
                    end
                end
            end

            if (cfg_we)
            begin
                case (cfg_index)
                    REG_CROSSING_THRESHOLD: thr_q     = cfg_data[THR_WIDTH-1:0];
                    REG_ZERO_BAND_UPPER:    band_hi_q = cfg_data[BAND_WIDTH-1:0];
                    REG_ZERO_BAND_LOWER:    band_lo_q = cfg_data[BAND_WIDTH-1:0];
                    REG_ZERO_HOLD_SAMPLES:  hold_q    = cfg_data[HOLD_WIDTH-1:0];
                    default: ;
                endcase
            end

            if (samples.valid && samples.ready)
            begin
                meter_step(samples.sample, want);
                pending_levels.push_back(want);
            end

            outstanding <= pending_levels.size();
        end
    end

endmodule

// ----- verif/half_cycle_average_meter_top_tb.sv -----
// Testbench top for the half-cycle average meter: clock, reset, stimulus and verdict.
`timescale 1ns / 1ps

module half_cycle_average_meter_top_tb;
    import hcam_pkg::*;

    localparam int     CLK_PERIOD_NS     = 8;
    localparam int     LONG_STALL_CYCLES = 400;
    localparam int     RAND_PHASES       = 6;
    localparam int     RAND_PER_PHASE    = 65;
    localparam int     SOAK_LEN          = 30;
    localparam int     DRAIN_CYCLES      = 40;
    localparam longint TIMEOUT_NS        = 20_000_000;

    logic                       clk       = 1'b0;
    logic                       rst_n     = 1'b0;
    logic                       cfg_we    = 1'b0;
    logic [CFG_INDEX_WIDTH-1:0] cfg_index = REG_CROSSING_THRESHOLD;
    logic [CFG_DATA_WIDTH-1:0]  cfg_data  = '0;

    logic idle_en   = 1'b0;
    logic stall_req = 1'b0;

    int mismatches;
    int outstanding;
    int beats_checked;
    int recomputes_seen;
    int clears_seen;
    int samples_sent    = 0;
    int settings_loaded = 0;

    // sample generator state
    int quiet_left = 0;
    int half_left  = 0;
    int half_amp   = 0;
    bit half_neg   = 1'b0;

    hcam_sample_if sample_ch ();
    hcam_result_if result_ch ();

    half_cycle_average_meter_top dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .samples   (sample_ch),
        .results   (result_ch),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    half_cycle_average_meter_checker meter_check (
        .clk             (clk),
        .rst_n           (rst_n),
        .samples         (sample_ch),
        .results         (result_ch),
        .cfg_we          (cfg_we),
        .cfg_index       (cfg_index),
        .cfg_data        (cfg_data),
        .mismatches      (mismatches),
        .outstanding     (outstanding),
        .beats_checked   (beats_checked),
        .recomputes_seen (recomputes_seen),
        .clears_seen     (clears_seen)
    );

    always #(CLK_PERIOD_NS / 2) clk = ~clk;

    // mostly short idles, now and then a long one
    function automatic int pick_gap();
        if ($urandom_range(0, 9) == 0)
            return $urandom_range(10, 60);
        return $urandom_range(0, 2);
    endfunction

    function automatic int next_gap(input bit drop_valid);
        int gap;
        gap = idle_en ? pick_gap() : 0;
        if (drop_valid && gap == 0)
            gap = 1;
        return gap;
    endfunction

    task automatic send_sample(input int v, input int gap);
        sample_ch.valid  <= 1'b1;
        sample_ch.sample <= v[SAMPLE_WIDTH_DEF-1:0];
        @(posedge clk);
        while (!sample_ch.ready)
            @(posedge clk);
        samples_sent++;
        if (gap > 0)
        begin
            sample_ch.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
    endtask

    // caller must have dropped valid on the last beat
    task automatic wait_for_results();
        while (outstanding != 0)
            @(posedge clk);
    endtask

    task automatic load_config(input int thr, input int hi, input int lo, input int hold);
        logic pad;
        pad = 1'($urandom_range(0, 1));
        cfg_we    <= 1'b1;
        cfg_index <= REG_CROSSING_THRESHOLD;
        cfg_data  <= {pad, thr[THR_WIDTH-1:0]};
        @(posedge clk);
        cfg_index <= REG_ZERO_BAND_UPPER;
        cfg_data  <= hi[BAND_WIDTH-1:0];
        @(posedge clk);
        cfg_index <= REG_ZERO_BAND_LOWER;
        cfg_data  <= lo[BAND_WIDTH-1:0];
        @(posedge clk);
        cfg_index <= REG_ZERO_HOLD_SAMPLES;
        cfg_data  <= hold[HOLD_WIDTH-1:0];
        @(posedge clk);
        cfg_we <= 1'b0;
        settings_loaded++;
    endtask

    task automatic play_directed(input int vals[]);
        foreach (vals[i])
            send_sample(vals[i], next_gap(i == vals.size() - 1));
    endtask

    // result sink
    initial
    begin : receiver
        forever
        begin
            if (stall_req)
            begin
                result_ch.ready <= 1'b0;
                repeat (LONG_STALL_CYCLES) @(posedge clk);
                stall_req       <= 1'b0;
                result_ch.ready <= 1'b1;
                @(posedge clk);
            end
            else if (idle_en && $urandom_range(0, 3) == 0)
            begin
                result_ch.ready <= 1'b0;
                repeat (pick_gap() + 1) @(posedge clk);
            end
            else
            begin
                result_ch.ready <= 1'b1;
                @(posedge clk);
            end
        end
    end

    initial
    begin : stimulus
        int thr;
        int hi;
        int lo;
        int hold;
        int v;
        bit pause;
        // reset registers: first crossing closes an empty half, then real halves
        int dir_reset[] = '{5, 32767, 32767, -32768, -32768, 0, 1, -1, 2, -2};
        // narrow band, short hold: timeout alone, then timeout with a crossing
        int dir_band[]  = '{0, 0, 0, 1, -1, 4, -4, 5};
        // top threshold, inverted band, zero hold
        int dir_hold0[] = '{32767, -32768, 100, -1};

        sample_ch.valid  <= 1'b0;
        sample_ch.sample <= '0;
        repeat (2) @(posedge clk);
        rst_n   <= 1'b1;
        idle_en <= 1'b1;
        @(posedge clk);

        play_directed(dir_reset);
        wait_for_results();
        load_config(0, 5, -5, 3);
        play_directed(dir_band);
        wait_for_results();
        load_config(32767, -32768, 32767, 0);
        play_directed(dir_hold0);

        for (int p = 0; p < RAND_PHASES; p++)
        begin
            wait_for_results();
            // two phases run with both sides fully streaming
            idle_en <= (p != 2 && p != 4);
            case ($urandom_range(0, 4))
                0:       thr = 0;
                1:       thr = 1;
                2:       thr = $urandom_range(2, 60);
                3:       thr = $urandom_range(0, 32767);
                default: thr = 32767;
            endcase
            case ($urandom_range(0, 5))
                0:
                begin
                    hi = 0;
                    lo = 0;
                end
                1, 5:
                begin
                    hi = $urandom_range(1, 40);
                    lo = -int'($urandom_range(1, 40));
                end
                2:
                begin
                    hi = int'($urandom_range(0, 65535)) - 32768;
                    lo = int'($urandom_range(0, 65535)) - 32768;
                end
                3:
                begin
                    hi = -32768;
                    lo = 32767;
                end
                default:
                begin
                    hi = 32767;
                    lo = -32768;
                end
            endcase
            case ($urandom_range(0, 5))
                0:       hold = 0;
                1:       hold = 1;
                2, 3:    hold = $urandom_range(2, 8);
                4:       hold = $urandom_range(0, 65535);
                default: hold = 65535;
            endcase
            load_config(thr, hi, lo, hold);
            quiet_left = 0;
            if (p == 1)
                stall_req <= 1'b1;

            for (int j = 0; j < RAND_PER_PHASE; j++)
            begin
                if (quiet_left == 0 && $urandom_range(0, 11) == 0)
                    quiet_left = $urandom_range(1, 12);
                if (quiet_left > 0)
                begin
                    quiet_left--;
                    if (hi - lo >= 2)
                        v = lo + 1 + int'($urandom_range(0, hi - lo - 2));
                    else
                        v = int'($urandom_range(0, 6)) - 3;
                end
                else if ($urandom_range(0, 9) == 0)
                    v = int'($urandom_range(0, 65535)) - 32768;
                else
                begin
                    // alternating half periods around the threshold
                    if (half_left == 0)
                    begin
                        half_neg  = !half_neg;
                        half_left = $urandom_range(1, 10);
                        half_amp  = ($urandom_range(0, 3) == 0 || thr > 16373) ? 32767
                                                                               : 2 * thr + 20;
                    end
                    half_left--;
                    v = $urandom_range(0, half_amp + (half_neg ? 1 : 0));
                    if (half_neg)
                        v = -v;
                end
                pause = (p == 3 && j == RAND_PER_PHASE / 2);
                send_sample(v, next_gap(pause || j == RAND_PER_PHASE - 1));
                if (pause)
                    wait_for_results();
            end
        end

        // long negative half period at full scale inside a full band, then one closing sample
        wait_for_results();
        idle_en <= 1'b0;
        load_config(1, 32767, -32768, 65535);
        send_sample(32767, 0);
        repeat (SOAK_LEN) send_sample(-32767, 0);
        send_sample(32767, 1);
        wait_for_results();
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("run: %0d samples over %0d register settings, %0d result beats checked",
                 samples_sent, settings_loaded, beats_checked);
        $display("run: %0d level recomputes, %0d zero-band clears, %0d-sample full-scale half",
                 recomputes_seen, clears_seen, SOAK_LEN);
        if (mismatches == 0 && outstanding == 0)
            $display("** half_cycle_average_meter_top: PASSED **");
        else
            $display("** half_cycle_average_meter_top: FAILED **");
        $finish;
    end

    initial
    begin : watchdog
        #(TIMEOUT_NS);
        $display("timeout: %0d results still outstanding", outstanding);
        $display("** half_cycle_average_meter_top: FAILED **");
        $finish;
    end

endmodule

// ----- filelist.f -----
src/hcam_pkg.sv
src/hcam_if.sv
src/hcam_cfg.sv
src/hcam_div.sv
src/half_cycle_average_meter_top.sv
verif/half_cycle_average_meter_checker.sv
verif/half_cycle_average_meter_top_tb.sv
